@@ hw/rtl/afr_pkg.sv @@
package afr_pkg;

    // Largest frame that fits the frame store, delimiter and checksum included
    localparam int MAX_FRAME_DEF = 13;

    localparam logic [7:0] DELIM       = 8'h7E;
    localparam logic [7:0] TYPE_RX     = 8'h81;
    localparam logic [7:0] STATUS_PAIR = 8'h02;
    localparam logic [7:0] CSUM_BASE   = 8'hFF;
    localparam int         OVERHEAD    = 4;

    // Fixed positions within a frame
    localparam int POS_LEN_HI  = 1;
    localparam int POS_LEN_LO  = 2;
    localparam int POS_TYPE    = 3;
    localparam int POS_ADDR_HI = 4;
    localparam int POS_ADDR_LO = 5;
    localparam int POS_STATUS  = 8;
    localparam int POS_JOY1    = 9;
    localparam int POS_JOY2    = 10;
    localparam int POS_BUTTONS = 11;

    // Frame status codes
    localparam logic [1:0] FS_GOOD     = 2'd0;
    localparam logic [1:0] FS_CSUM_ERR = 2'd1;
    localparam logic [1:0] FS_BAD_TYPE = 2'd2;

    typedef struct packed {
        logic [1:0]  frame_status;
        logic [15:0] source_address;
        logic [7:0]  status_value;
        logic [7:0]  joystick_one;
        logic [7:0]  joystick_two;
        logic [7:0]  button_bits;
        logic        paired;
        logic        pair_event;
    } res_t;

endpackage

@@ hw/rtl/api_frame_receiver.sv @@
// Byte-serial API frame receiver. Takes one received byte per cycle on the rx
// channel: it hunts for the 0x7E delimiter, reads the 16-bit length from the
// next two bytes, sums the payload and, on the last byte of the frame, checks
// the checksum and the frame type (0x81). Every completed frame gives one
// result transaction through the output registers, with the frame status and
// the address, status, joystick and button fields latched from the last good
// frame (all ones until the first one), plus a sticky paired flag and a
// one-shot pair_event. Frames longer than MAX_FRAME bytes are dropped with no
// result. Throughput is one byte per cycle; the only back-pressure comes from
// the two-entry output buffer (result register plus skid register), which
// raises rx_stall only when both entries are full.
module api_frame_receiver #(
    parameter int MAX_FRAME = afr_pkg::MAX_FRAME_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,

    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  frame_status,
    output logic [15:0] source_address,
    output logic [7:0]  status_value,
    output logic [7:0]  joystick_one,
    output logic [7:0]  joystick_two,
    output logic [7:0]  button_bits,
    output logic        paired,
    output logic        pair_event
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);

    // Receive state
    logic             receiving_reg;
    logic [CNT_W-1:0] byte_count_reg;
    logic [CNT_W-1:0] expected_size_reg;
    logic             expected_ok_reg;
    logic [7:0]       running_sum_reg;

    // Frame store, only the positions that are ever read back
    logic [7:0]       len_hi_reg;
    logic [7:0]       type_reg;
    logic [7:0]       addr_hi_reg;
    logic [7:0]       addr_lo_reg;
    logic [7:0]       status_reg;
    logic [7:0]       joy1_reg;
    logic [7:0]       joy2_reg;
    logic [7:0]       buttons_reg;

    // Latched fields of the last good frame
    logic [15:0]      held_addr_reg;
    logic [7:0]       held_status_reg;
    logic [7:0]       held_joy1_reg;
    logic [7:0]       held_joy2_reg;
    logic [7:0]       held_buttons_reg;
    logic             paired_reg;

    // Output buffer
    logic             out_valid_reg;
    afr_pkg::res_t    out_reg;
    logic             skid_valid_reg;
    afr_pkg::res_t    skid_reg;

    logic             rx_fire;
    logic             out_fire;
    logic             in_frame;
    logic [CNT_W-1:0] cnt_next;
    logic [7:0]       len_hi_eff;
    logic [7:0]       type_eff;
    logic [7:0]       addr_hi_eff;
    logic [7:0]       addr_lo_eff;
    logic [7:0]       status_eff;
    logic [7:0]       joy1_eff;
    logic [7:0]       joy2_eff;
    logic [7:0]       buttons_eff;
    logic [16:0]      exp_full;
    logic             exp_fits;
    logic [CNT_W-1:0] exp_eff;
    logic             exp_ok_eff;
    logic             at_len_lo;
    logic             frame_done;
    logic             csum_ok;
    logic             type_ok;
    logic             good;
    logic             pair_set;
    logic             res_new;
    afr_pkg::res_t    res_data;

    assign rx_stall = skid_valid_reg;
    assign rx_fire  = rx_valid && !rx_stall;
    assign out_fire = out_valid_reg && !res_stall;

    // A byte that lands inside the store; the one at position MAX_FRAME drops the frame
    assign in_frame = receiving_reg && (byte_count_reg < CNT_W'(MAX_FRAME));
    assign cnt_next = byte_count_reg + CNT_W'(1);

    // Store contents as seen after this byte is written
    always_comb
    begin
        len_hi_eff  = (byte_count_reg == CNT_W'(afr_pkg::POS_LEN_HI))  ? rx_byte : len_hi_reg;
        type_eff    = (byte_count_reg == CNT_W'(afr_pkg::POS_TYPE))    ? rx_byte : type_reg;
        addr_hi_eff = (byte_count_reg == CNT_W'(afr_pkg::POS_ADDR_HI)) ? rx_byte : addr_hi_reg;
        addr_lo_eff = (byte_count_reg == CNT_W'(afr_pkg::POS_ADDR_LO)) ? rx_byte : addr_lo_reg;
        status_eff  = (byte_count_reg == CNT_W'(afr_pkg::POS_STATUS))  ? rx_byte : status_reg;
        joy1_eff    = (byte_count_reg == CNT_W'(afr_pkg::POS_JOY1))    ? rx_byte : joy1_reg;
        joy2_eff    = (byte_count_reg == CNT_W'(afr_pkg::POS_JOY2))    ? rx_byte : joy2_reg;
        buttons_eff = (byte_count_reg == CNT_W'(afr_pkg::POS_BUTTONS)) ? rx_byte : buttons_reg;
    end

    // Frame size from the length field; a size beyond the store can never complete
    assign at_len_lo  = (byte_count_reg == CNT_W'(afr_pkg::POS_LEN_LO));
    assign exp_full   = {1'b0, len_hi_eff, rx_byte} + 17'(afr_pkg::OVERHEAD);
    assign exp_fits   = (exp_full <= 17'(MAX_FRAME));
    assign exp_eff    = at_len_lo ? exp_full[CNT_W-1:0] : expected_size_reg;
    assign exp_ok_eff = at_len_lo ? exp_fits : expected_ok_reg;

    assign frame_done = in_frame && exp_ok_eff && (cnt_next == exp_eff);
    assign csum_ok    = ((afr_pkg::CSUM_BASE - running_sum_reg) == rx_byte);
    assign type_ok    = (type_eff == afr_pkg::TYPE_RX);
    assign good       = csum_ok && type_ok;
    assign pair_set   = good && (status_eff == afr_pkg::STATUS_PAIR) && !paired_reg;
    assign res_new    = rx_fire && frame_done;

    always_comb
    begin
        if (!csum_ok)
        begin
            res_data.frame_status = afr_pkg::FS_CSUM_ERR;
        end
        else if (!type_ok)
        begin
            res_data.frame_status = afr_pkg::FS_BAD_TYPE;
        end
        else
        begin
            res_data.frame_status = afr_pkg::FS_GOOD;
        end
        if (good)
        begin
            res_data.source_address = {addr_hi_eff, addr_lo_eff};
            res_data.status_value   = status_eff;
            res_data.joystick_one   = joy1_eff;
            res_data.joystick_two   = joy2_eff;
            res_data.button_bits    = buttons_eff;
        end
        else
        begin
            res_data.source_address = held_addr_reg;
            res_data.status_value   = held_status_reg;
            res_data.joystick_one   = held_joy1_reg;
            res_data.joystick_two   = held_joy2_reg;
            res_data.button_bits    = held_buttons_reg;
        end
        res_data.paired     = paired_reg || pair_set;
        res_data.pair_event = pair_set;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg     <= 1'b0;
            byte_count_reg    <= '0;
            expected_size_reg <= '0;
            expected_ok_reg   <= 1'b0;
            running_sum_reg   <= '0;
            len_hi_reg        <= '0;
            type_reg          <= '0;
            addr_hi_reg       <= '0;
            addr_lo_reg       <= '0;
            status_reg        <= '0;
            joy1_reg          <= '0;
            joy2_reg          <= '0;
            buttons_reg       <= '0;
            held_addr_reg     <= '1;
            held_status_reg   <= '1;
            held_joy1_reg     <= '1;
            held_joy2_reg     <= '1;
            held_buttons_reg  <= '1;
            paired_reg        <= 1'b0;
        end
        else if (rx_fire)
        begin
            if (!receiving_reg)
            begin
                // Hunt for the delimiter, ignore noise
                if (rx_byte == afr_pkg::DELIM)
                begin
                    receiving_reg   <= 1'b1;
                    byte_count_reg  <= CNT_W'(1);
                    running_sum_reg <= '0;
                end
            end
            else if (!in_frame)
            begin
                // Oversize: drop the frame
                receiving_reg  <= 1'b0;
                byte_count_reg <= '0;
            end
            else
            begin
                len_hi_reg  <= len_hi_eff;
                type_reg    <= type_eff;
                addr_hi_reg <= addr_hi_eff;
                addr_lo_reg <= addr_lo_eff;
                status_reg  <= status_eff;
                joy1_reg    <= joy1_eff;
                joy2_reg    <= joy2_eff;
                buttons_reg <= buttons_eff;
                if (at_len_lo)
                begin
                    expected_size_reg <= exp_full[CNT_W-1:0];
                    expected_ok_reg   <= exp_fits;
                end
                if (frame_done)
                begin
                    receiving_reg  <= 1'b0;
                    byte_count_reg <= '0;
                    if (good)
                    begin
                        held_addr_reg    <= {addr_hi_eff, addr_lo_eff};
                        held_status_reg  <= status_eff;
                        held_joy1_reg    <= joy1_eff;
                        held_joy2_reg    <= joy2_eff;
                        held_buttons_reg <= buttons_eff;
                    end
                    if (pair_set)
                    begin
                        paired_reg <= 1'b1;
                    end
                end
                else
                begin
                    byte_count_reg <= cnt_next;
                    if (byte_count_reg >= CNT_W'(afr_pkg::POS_TYPE))
                    begin
                        running_sum_reg <= running_sum_reg + rx_byte;
                    end
                end
            end
        end
    end

    // Result register with a skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_new;
            end
        end
        else if (res_new)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res_data;
        end
        if (res_new)
        begin
            skid_reg <= res_data;
        end
    end

    assign res_valid      = out_valid_reg;
    assign frame_status   = out_reg.frame_status;
    assign source_address = out_reg.source_address;
    assign status_value   = out_reg.status_value;
    assign joystick_one   = out_reg.joystick_one;
    assign joystick_two   = out_reg.joystick_two;
    assign button_bits    = out_reg.button_bits;
    assign paired         = out_reg.paired;
    assign pair_event     = out_reg.pair_event;

endmodule
